// ===== hdl/cps_pkg.sv =====
// ---------------------------------------------------------------------------
// Class pattern search package
// Request and response payload types, request codes, element kinds and the
// per-cell control bundle shared by the search chain.
// ---------------------------------------------------------------------------
package cps_pkg;

   // Request function codes.
   localparam logic [1:0] FUNC_KIND   = 2'd0;
   localparam logic [1:0] FUNC_MEMBER = 2'd1;
   localparam logic [1:0] FUNC_TEXT   = 2'd2;
   localparam logic [1:0] FUNC_END    = 2'd3;

   // Element kinds. Codes 6 and 7 are stored but never match.
   localparam logic [2:0] KIND_LITERAL = 3'd0;
   localparam logic [2:0] KIND_LETTER  = 3'd1;
   localparam logic [2:0] KIND_SET     = 3'd2;
   localparam logic [2:0] KIND_NOTSET  = 3'd3;
   localparam logic [2:0] KIND_LOWER   = 3'd4;
   localparam logic [2:0] KIND_UPPER   = 3'd5;

   // ASCII letter bounds.
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] element_index;
      logic [2:0] element_kind;
      logic [7:0] char_value;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] match_start;
      logic        overflowed;
   } rsp_type;

   // Control bundle from the top level to one cell.
   typedef struct packed {
      logic wr_kind;     // rewrite this element and empty its set
      logic add_member;  // append a member to this element's set
      logic text;        // a text character is being consumed
      logic clear;       // end of text: drop the active bit
   } cell_ctl_type;

endpackage

// ===== hdl/class_pattern_search_top.sv =====
// ---------------------------------------------------------------------------
// Class pattern search, top level
// Shift-and search of a character-class pattern over a streamed text, with
// one cell per pattern element and a single response at end of text.
// ---------------------------------------------------------------------------
//
//   Channel   Ports              Direction  Payload
//   request   req_valid/ready    in         cps_pkg::req_type
//   response  rsp_valid/ready    out        cps_pkg::rsp_type
//   csr       csr_wr_en/wr_data  in         pattern length, 5 bits
//
// A new request is taken every cycle unless an end of text stalls, as below. The
// cell chain updates all active bits for a text character at once.
// The response sits in an output register, and requests keep flowing while
// it waits; only an end-of-text request stalls while that register is full
// and not being drained. Reset is synchronous and clears the active bits,
// set counts, position and flags and sets the pattern length to one; the
// element kinds, literals and set members hold no reset value.
module class_pattern_search_top #(
   parameter int PATTERN_MAX = 16,
   parameter int SET_MAX     = 8,
   parameter int POS_BITS    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cps_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data
);
   import cps_pkg::*;

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic                   req_fire;
   logic                   is_kind;
   logic                   is_member;
   logic                   is_text;
   logic                   is_end;

   logic [IDX_W-1:0]       last_idx_ff;
   logic [IDX_W-1:0]       last_idx_in;

   logic [PATTERN_MAX-1:0] act_vec;
   logic [PATTERN_MAX-1:0] next_vec;
   logic [PATTERN_MAX-1:0] prev_vec;
   logic [PATTERN_MAX-1:0] use_vec;
   cell_ctl_type           ctl_vec [PATTERN_MAX];

   logic [POS_BITS-1:0]    pos_ff;
   logic [POS_BITS-1:0]    pos_in;
   logic [POS_BITS-1:0]    first_ff;
   logic [POS_BITS-1:0]    first_in;
   logic [POS_BITS-1:0]    last_ext;
   logic                   found_ff;
   logic                   found_in;
   logic                   ovf_ff;
   logic                   ovf_in;
   logic [POS_BITS+15:0]   start_ext;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_data_ff;

   // An end-of-text request needs the response register free or draining;
   // every other request is always taken.
   assign req_ready = !rsp_valid_ff || rsp_ready || (req_data.func != FUNC_END);
   assign req_fire  = req_valid && req_ready;
   assign is_kind   = req_fire && (req_data.func == FUNC_KIND);
   assign is_member = req_fire && (req_data.func == FUNC_MEMBER);
   assign is_text   = req_fire && (req_data.func == FUNC_TEXT);
   assign is_end    = req_fire && (req_data.func == FUNC_END);

   // The pattern length is kept as the index of the last element in use,
   // with zero treated as one and large values clamped to the chain length.
   always_comb begin
      last_idx_in = last_idx_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == 5'd0) begin
            last_idx_in = '0;
         end else if (32'(csr_wr_data) > PATTERN_MAX) begin
            last_idx_in = IDX_W'(PATTERN_MAX - 1);
         end else begin
            last_idx_in = IDX_W'(csr_wr_data - 5'd1);
         end
      end
   end

   // The chain of element cells. Cell zero always sees an active predecessor,
   // so a match may begin at any text character.
   for (genvar e = 0; e < PATTERN_MAX; e++) begin : g_cell
      logic sel;

      assign sel                 = (32'(req_data.element_index) == e);
      assign ctl_vec[e].wr_kind    = is_kind && sel;
      assign ctl_vec[e].add_member = is_member && sel;
      assign ctl_vec[e].text       = is_text;
      assign ctl_vec[e].clear      = is_end;
      assign use_vec[e]          = (32'(last_idx_ff) >= e);

      if (e == 0) begin : g_head
         assign prev_vec[e] = 1'b1;
      end else begin : g_link
         assign prev_vec[e] = act_vec[e-1];
      end

      cps_cell #(
         .SET_MAX (SET_MAX)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl_vec[e]),
         .kind_wr    (req_data.element_kind),
         .char_value (req_data.char_value),
         .in_use     (use_vec[e]),
         .act_prev   (prev_vec[e]),
         .act_next   (next_vec[e]),
         .act_out    (act_vec[e])
      );
   end

   // Position counting, first match capture and overflow tracking.
   assign last_ext = POS_BITS'(last_idx_ff);

   always_comb begin
      pos_in   = pos_ff;
      first_in = first_ff;
      found_in = found_ff;
      ovf_in   = ovf_ff;
      if (is_end) begin
         pos_in   = '0;
         first_in = '0;
         found_in = 1'b0;
         ovf_in   = 1'b0;
      end else if (is_text) begin
         if (!found_ff && next_vec[last_idx_ff]) begin
            found_in = 1'b1;
            first_in = (pos_ff >= last_ext) ? (pos_ff - last_ext) : '0;
         end
         if (pos_ff == {POS_BITS{1'b1}}) begin
            ovf_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_BITS'(1);
         end
      end
   end

   // The reported start is the low sixteen bits of the stored start.
   assign start_ext = {16'd0, first_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (is_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_idx_ff  <= '0;
         pos_ff       <= '0;
         first_ff     <= '0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_idx_ff  <= last_idx_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_end) begin
         rsp_data_ff.found       <= found_ff;
         rsp_data_ff.match_start <= found_ff ? start_ext[15:0] : 16'd0;
         rsp_data_ff.overflowed  <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/cps_cell.sv =====
// ---------------------------------------------------------------------------
// Class pattern search cell
// One pattern element: its kind, literal, set members and active bit. The
// active bit comes in from the left neighbor and goes out to the right.
// ---------------------------------------------------------------------------
module cps_cell #(
   parameter int SET_MAX = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cps_pkg::cell_ctl_type ctl,
   input  logic [2:0]           kind_wr,
   input  logic [7:0]           char_value,
   input  logic                 in_use,
   input  logic                 act_prev,
   output logic                 act_next,
   output logic                 act_out
);
   import cps_pkg::*;

   localparam int CNT_W = $clog2(SET_MAX + 1);

   logic [2:0]         kind_ff;
   logic [7:0]         literal_ff;
   logic [7:0]         member_ff [SET_MAX];
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic               act_ff;
   logic               act_in;
   logic [SET_MAX-1:0] hit;
   logic               in_set;
   logic               is_lower;
   logic               is_upper;
   logic               accept;

   // Each member lane compares against the current character in parallel.
   always_comb begin
      for (int k = 0; k < SET_MAX; k++) begin
         hit[k] = (CNT_W'(k) < cnt_ff) && (member_ff[k] == char_value);
      end
   end

   assign in_set   = |hit;
   assign is_lower = (char_value >= CHAR_LOWER_A) && (char_value <= CHAR_LOWER_Z);
   assign is_upper = (char_value >= CHAR_UPPER_A) && (char_value <= CHAR_UPPER_Z);

   always_comb begin
      case (kind_ff)
         KIND_LITERAL: accept = (literal_ff == char_value);
         KIND_LETTER:  accept = is_lower || is_upper;
         KIND_SET:     accept = in_set;
         KIND_NOTSET:  accept = !in_set;
         KIND_LOWER:   accept = is_lower;
         KIND_UPPER:   accept = is_upper;
         default:      accept = 1'b0;
      endcase
   end

   assign act_next = in_use && act_prev && accept;
   assign act_out  = act_ff;

   always_comb begin
      act_in = act_ff;
      if (ctl.clear) begin
         act_in = 1'b0;
      end else if (ctl.text) begin
         act_in = act_next;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.wr_kind) begin
         cnt_in = '0;
      end else if (ctl.add_member && (cnt_ff < CNT_W'(SET_MAX))) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         act_ff <= act_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_kind) begin
         kind_ff    <= kind_wr;
         literal_ff <= char_value;
      end
      for (int k = 0; k < SET_MAX; k++) begin
         if (ctl.add_member && !ctl.wr_kind && (cnt_ff == CNT_W'(k))) begin
            member_ff[k] <= char_value;
         end
      end
   end

endmodule

// ===== hdl/cps_checker.sv =====
// ---------------------------------------------------------------------------
// Class pattern search checker
// Port-level properties of the search block, bound to the top level.
// ---------------------------------------------------------------------------
module cps_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input cps_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cps_pkg::rsp_type rsp_data
);
   import cps_pkg::*;

   // A response waits with its payload held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // A response appears only after an end-of-text request was taken.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_data.func == FUNC_END)))
      else $error("response without end-of-text request");

   // A full, stalled response register refuses another end of text.
   a_end_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && (req_data.func == FUNC_END) |-> !req_ready)
      else $error("end of text taken over a pending response");

   // No match means a zero start.
   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> (rsp_data.match_start == 16'd0))
      else $error("start reported without a match");

endmodule

bind class_pattern_search_top cps_checker u_cps_checker (.*);
